>>> rtl/core/bdc_pkg.sv
// Braille dot canvas plotter: shared constants, types and helper functions.
// No dependencies; bdc_addr_map, bdc_cell_ram and the top unit refer to this package.
`default_nettype none

package bdc_pkg;

    localparam int DEFAULT_PIXEL_ROWS = 48;
    localparam int DEFAULT_PIXEL_COLS = 128;

    localparam logic [1:0] OP_PLOT  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [13:0] BRAILLE_BASE = 14'h2800;

    // one word of the cell store
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] dots;
    } cell_t;

    // decoded input item
    typedef struct packed {
        logic       plot;
        logic       clear;
        logic       read;
        logic       hit;   // plot on canvas, or read of an existing cell
        logic [7:0] dot;   // dot bit for a plot
    } dec_t;

    // braille dot numbering: left column 1,2,3,7 and right column 4,5,6,8
    function automatic logic [7:0] dot_bit(input logic [1:0] row, input logic col);
        logic [7:0] bits;
        unique case ({row, col})
            3'b00_0: bits = 8'h01;
            3'b00_1: bits = 8'h08;
            3'b01_0: bits = 8'h02;
            3'b01_1: bits = 8'h10;
            3'b10_0: bits = 8'h04;
            3'b10_1: bits = 8'h20;
            3'b11_0: bits = 8'h40;
            3'b11_1: bits = 8'h80;
            default: bits = 8'h00;
        endcase
        return bits;
    endfunction

    // floor of the mean of two channel values
    function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8:1];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bdc_in_if.sv
// Input channel of the braille canvas plotter: valid/ready plus item fields.
// No dependencies.
`default_nettype none

interface bdc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [5:0]         cell_col;
    logic [3:0]         cell_row;

    modport source (
        output valid, op, pixel_x, pixel_y, red_in, green_in, blue_in, cell_col, cell_row,
        input  ready
    );
    modport sink (
        input  valid, op, pixel_x, pixel_y, red_in, green_in, blue_in, cell_col, cell_row,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/bdc_out_if.sv
// Result channel of the braille canvas plotter: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface bdc_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [7:0]  dot_mask;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [13:0] code_point;
    logic        blank;

    modport source (
        output valid, accepted, dot_mask, red_out, green_out, blue_out, code_point, blank,
        input  ready
    );
    modport sink (
        input  valid, accepted, dot_mask, red_out, green_out, blue_out, code_point, blank,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/bdc_cell_ram.sv
// Cell store: one write port, one read port, registered read data.
// Depends on bdc_pkg (cell_t).
`default_nettype none

module bdc_cell_ram #(
    parameter  int DEPTH  = 768,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [ADDR_W-1:0]   waddr,
    input  wire bdc_pkg::cell_t      wdata,
    input  wire logic                re,
    input  wire logic [ADDR_W-1:0]   raddr,
    output      bdc_pkg::cell_t      rdata
);

    bdc_pkg::cell_t mem [DEPTH];
    bdc_pkg::cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read before write on a shared address
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/bdc_addr_map.sv
// Decodes an input item: op, canvas range checks, dot bit and cell address.
// Depends on bdc_pkg (dec_t, op codes, dot_bit).
`default_nettype none

module bdc_addr_map #(
    parameter  int PIXEL_ROWS = bdc_pkg::DEFAULT_PIXEL_ROWS,
    parameter  int PIXEL_COLS = bdc_pkg::DEFAULT_PIXEL_COLS,
    localparam int CELL_ROWS  = (PIXEL_ROWS + 3) / 4,
    localparam int CELL_COLS  = (PIXEL_COLS + 1) / 2,
    localparam int CELL_COUNT = CELL_ROWS * CELL_COLS,
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
    input  wire logic [1:0]         op,
    input  wire logic signed [15:0] pixel_x,
    input  wire logic signed [15:0] pixel_y,
    input  wire logic [5:0]         cell_col,
    input  wire logic [3:0]         cell_row,
    output      bdc_pkg::dec_t      dec,
    output      logic [ADDR_W-1:0]  addr
);

    logic              plot_ok;
    logic              read_ok;
    logic [ADDR_W-1:0] plot_addr;
    logic [ADDR_W-1:0] read_addr;

    always_comb
    begin
        plot_ok = !pixel_x[15] && !pixel_y[15]
               && ({1'b0, pixel_x[14:0]} < 16'(PIXEL_COLS))
               && ({1'b0, pixel_y[14:0]} < 16'(PIXEL_ROWS));
        read_ok = (9'(cell_col) < 9'(CELL_COLS)) && (7'(cell_row) < 7'(CELL_ROWS));

        // values off the canvas may alias; they never reach the store
        plot_addr = ADDR_W'(pixel_y[15:2]) * ADDR_W'(CELL_COLS) + ADDR_W'(pixel_x[15:1]);
        read_addr = ADDR_W'(cell_row) * ADDR_W'(CELL_COLS) + ADDR_W'(cell_col);

        dec.plot  = (op == bdc_pkg::OP_PLOT);
        dec.clear = (op == bdc_pkg::OP_CLEAR);
        dec.read  = (op == bdc_pkg::OP_READ);
        dec.hit   = (dec.plot && plot_ok) || (dec.read && read_ok);
        dec.dot   = bdc_pkg::dot_bit(pixel_y[1:0], pixel_x[0]);

        addr = dec.plot ? plot_addr : read_addr;
    end

endmodule

`default_nettype wire

>>> rtl/core/bdc_clear_seq.sv
// Clearing sweep over the cell store, one entry a cycle, after reset or on request.
// Depends on nothing but its parameter.
`default_nettype none

module bdc_clear_seq #(
    parameter  int DEPTH  = 768,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output      logic              busy,
    output      logic [ADDR_W-1:0] addr
);

    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;

    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            addr_next = '0;
        end
        else if (busy_reg && addr_reg == LAST)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            addr_next = addr_reg + ADDR_W'(1);
        end
    end

    // the sweep also runs out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign busy = busy_reg;
    assign addr = addr_reg;

endmodule

`default_nettype wire

>>> rtl/core/braille_dot_canvas_plotter_unit.sv
// Braille dot canvas plotter: an accepted item passes the stage 1 register and then
// the output register. Plot and read items run at one item per cycle while the result
// port is ready (one store read, one write per cycle). A clear item's result leaves
// as usual; the input then stalls while the clear is in stage 1 and during the store
// sweep. Reset is asynchronous, active low, and starts a sweep of the store to zero.
// Depends on bdc_pkg, bdc_in_if, bdc_out_if, bdc_addr_map, bdc_cell_ram, bdc_clear_seq.
`default_nettype none

module braille_dot_canvas_plotter_unit #(
    parameter  int PIXEL_ROWS = bdc_pkg::DEFAULT_PIXEL_ROWS,
    parameter  int PIXEL_COLS = bdc_pkg::DEFAULT_PIXEL_COLS,
    localparam int CELL_ROWS  = (PIXEL_ROWS + 3) / 4,
    localparam int CELL_COLS  = (PIXEL_COLS + 1) / 2,
    localparam int CELL_COUNT = CELL_ROWS * CELL_COLS,
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bdc_in_if.sink     req,
    bdc_out_if.source  rsp
);

    // ------------------------------------------------------------------
    // Stage 0: decode the item, issue the store read
    // ------------------------------------------------------------------
    bdc_pkg::dec_t     map_dec;
    logic [ADDR_W-1:0] map_addr;

    bdc_addr_map #(
        .PIXEL_ROWS (PIXEL_ROWS),
        .PIXEL_COLS (PIXEL_COLS)
    ) u_map (
        .op       (req.op),
        .pixel_x  (req.pixel_x),
        .pixel_y  (req.pixel_y),
        .cell_col (req.cell_col),
        .cell_row (req.cell_row),
        .dec      (map_dec),
        .addr     (map_addr)
    );

    logic              req_fire;
    logic              s1_fire;
    logic              clr_busy;
    logic [ADDR_W-1:0] clr_addr;
    logic              clr_start;

    // Stage 1 registers: item waiting for its store data
    logic              s1_valid_reg;
    bdc_pkg::dec_t     s1_dec_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [7:0]        s1_red_reg;
    logic [7:0]        s1_green_reg;
    logic [7:0]        s1_blue_reg;

    // Forwarding: the write of the item ahead lands at the edge this item reads,
    // so the read returns the old word; keep the written word instead.
    logic              fwd_hit_reg;
    bdc_pkg::cell_t    fwd_data_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_accepted_reg;
    logic [7:0]        out_dots_reg;
    logic [7:0]        out_red_reg;
    logic [7:0]        out_green_reg;
    logic [7:0]        out_blue_reg;

    // Store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    bdc_pkg::cell_t    ram_wdata;
    bdc_pkg::cell_t    ram_rdata;
    logic              plot_we;

    // Stage 1 may move on when the output register is free or being emptied.
    // No item enters during the sweep, nor while a clear waits in stage 1,
    // so the sweep never races an item's read.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clr_busy && !(s1_valid_reg && s1_dec_reg.clear)
                    && (!s1_valid_reg || s1_fire);
    assign req_fire = req.valid && req.ready;

    bdc_cell_ram #(
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (req_fire),
        .raddr (map_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: modify and write back, build the result
    // ------------------------------------------------------------------
    bdc_pkg::cell_t cur_cell;
    bdc_pkg::cell_t upd_cell;
    logic           show_cell;
    logic           res_accepted;

    always_comb
    begin
        cur_cell = fwd_hit_reg ? fwd_data_reg : ram_rdata;

        upd_cell.dots  = cur_cell.dots | s1_dec_reg.dot;
        upd_cell.red   = bdc_pkg::avg8(cur_cell.red,   s1_red_reg);
        upd_cell.green = bdc_pkg::avg8(cur_cell.green, s1_green_reg);
        upd_cell.blue  = bdc_pkg::avg8(cur_cell.blue,  s1_blue_reg);

        plot_we   = s1_fire && s1_dec_reg.plot && s1_dec_reg.hit;
        show_cell = s1_dec_reg.read && s1_dec_reg.hit;
        // only a plot off the canvas is refused
        res_accepted = !(s1_dec_reg.plot && !s1_dec_reg.hit);

        // the sweep owns the write port while it runs; stage 1 is empty then
        ram_we    = clr_busy || plot_we;
        ram_waddr = clr_busy ? clr_addr : s1_addr_reg;
        ram_wdata = clr_busy ? '0 : upd_cell;
    end

    assign clr_start = s1_fire && s1_dec_reg.clear;

    bdc_clear_seq #(
        .DEPTH (CELL_COUNT)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .start (clr_start),
        .busy  (clr_busy),
        .addr  (clr_addr)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_dec_reg   <= map_dec;
            s1_addr_reg  <= map_addr;
            s1_red_reg   <= req.red_in;
            s1_green_reg <= req.green_in;
            s1_blue_reg  <= req.blue_in;
            fwd_hit_reg  <= plot_we && (s1_addr_reg == map_addr);
            fwd_data_reg <= upd_cell;
        end

        if (s1_fire)
        begin
            out_accepted_reg <= res_accepted;
            out_dots_reg     <= show_cell ? cur_cell.dots  : 8'h00;
            out_red_reg      <= show_cell ? cur_cell.red   : 8'h00;
            out_green_reg    <= show_cell ? cur_cell.green : 8'h00;
            out_blue_reg     <= show_cell ? cur_cell.blue  : 8'h00;
        end
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    assign rsp.valid      = out_valid_reg;
    assign rsp.accepted   = out_accepted_reg;
    assign rsp.dot_mask   = out_dots_reg;
    assign rsp.red_out    = out_red_reg;
    assign rsp.green_out  = out_green_reg;
    assign rsp.blue_out   = out_blue_reg;
    // low byte of the base is zero, so the sum is an OR
    assign rsp.code_point = bdc_pkg::BRAILLE_BASE | {6'b0, out_dots_reg};
    assign rsp.blank      = (out_dots_reg == 8'h00);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_item_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !req_fire)
        else $error("item taken while the store is being cleared");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !plot_we)
        else $error("plot write collides with the clearing sweep");

    a_off_canvas_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_dec_reg.plot && !s1_dec_reg.hit) |=> (out_valid_reg && !out_accepted_reg))
        else $error("off-canvas plot not flagged");

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_dec_reg.clear) |=> clr_busy)
        else $error("clear item did not start the sweep");

endmodule

`default_nettype wire
